[hw/rtl/audio_jitter_buffer_top_assert.svh]
// assertion macros for the audio jitter buffer
`ifndef AUDIO_JITTER_BUFFER_TOP_ASSERT_SVH
`define AUDIO_JITTER_BUFFER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define AJB_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("ajb assertion failed");
`define AJB_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("ajb assertion failed");
`else
`define AJB_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define AJB_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

[hw/rtl/ajb_pkg.sv]
// types and constants of the audio jitter buffer
package ajb_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int FILL_W    = 13;
    localparam int THR_W     = 13;
    localparam int FLEN_W    = 11;
    localparam int POS_W     = 10;
    localparam int CFG_DATA_W = 13;

    localparam logic [THR_W-1:0]  THR_RESET  = 13'd8000;
    localparam logic [FLEN_W-1:0] FLEN_RESET = 11'd320;
    localparam logic [FLEN_W-1:0] FLEN_MAX   = 11'd1024;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_PUSH = 2'd0;
    localparam mode_t MODE_PULL = 2'd1;

    localparam logic CFG_PREBUF = 1'b0;
    localparam logic CFG_FRAME  = 1'b1;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_DROPPED = 3'd1,
        ST_PREBUF  = 3'd2,
        ST_RING    = 3'd3,
        ST_SILENCE = 3'd4,
        ST_CLIENT  = 3'd5
    } status_t;

    typedef struct packed {
        mode_t                      mode;
        logic signed [SAMPLE_W-1:0] sample_in;
    } in_word_t;

    typedef struct packed {
        status_t                    status;
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       frame_last;
        logic [FILL_W-1:0]          fill_level;
    } out_word_t;

endpackage

[hw/rtl/audio_jitter_buffer_top.sv]
// audio jitter buffer: sample ring memory with prebuffer gating and framed pull
// a result passes through the access stage register and then the output register once its word is accepted
// throughput: one word per cycle while result_ready does not stall the output, set by the sample memory access
// pointers, frame state and the read data register all update at the end of the accept cycle
// reset clears pointers, flags and frame position and loads the register defaults
// the sample memory has no clearing pass; entries are valid once written
module audio_jitter_buffer_top #(
    parameter int RING_DEPTH = 8192
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  ajb_pkg::in_word_t                   item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output ajb_pkg::out_word_t                  result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [ajb_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ajb_pkg::*;

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = (PW > THR_W) ? PW : THR_W;
    localparam logic [PW-1:0] LAST_ADDR = PW'(RING_DEPTH - 1);
    localparam logic [PW:0]   DEPTH_EXT = (PW+1)'(RING_DEPTH);

    // sample memory
    logic [SAMPLE_W-1:0] mem [RING_DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;

    // control state
    logic [PW-1:0]     wp_reg, wp_next;
    logic [PW-1:0]     rp_reg, rp_next;
    logic              started_reg, started_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              silent_reg, silent_next;
    logic [THR_W-1:0]  thr_reg;
    logic [FLEN_W-1:0] flen_reg;

    // access stage
    logic              s1_valid_reg;
    status_t           s1_status_reg, st;
    logic              s1_last_reg, last;
    logic [FILL_W-1:0] s1_fill_reg;
    logic              s1_ring_reg;

    out_word_t out_reg;
    logic      out_valid_reg;

    logic              accept, s1_adv, wr_en, rd_en;
    logic [PW-1:0]     fill, fill_after;
    logic [PW:0]       diff;
    logic [CW-1:0]     fill_ext;
    logic [FLEN_W-1:0] flen;
    logic              full, started_now, silent_now;

    assign s1_adv     = !out_valid_reg || result_ready;
    assign item_ready = !s1_valid_reg || s1_adv;
    assign accept     = item_valid && item_ready;
    assign cfg_ready  = 1'b1;

    assign diff = {1'b0, wp_reg} + ((wp_reg < rp_reg) ? DEPTH_EXT : '0) - {1'b0, rp_reg};
    assign fill     = diff[PW-1:0];
    assign fill_ext = CW'(fill);
    assign full     = (fill == LAST_ADDR);

    always_comb
    begin
        if (flen_reg == '0)
            flen = FLEN_W'(1);
        else if (flen_reg > FLEN_MAX)
            flen = FLEN_MAX;
        else
            flen = flen_reg;
    end

    always_comb
    begin
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        started_next = started_reg;
        pos_next     = pos_reg;
        silent_next  = silent_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        st           = ST_CLIENT;
        last         = 1'b0;
        fill_after   = fill;
        started_now  = started_reg;
        silent_now   = silent_reg;
        if (accept)
        begin
            unique case (item.mode)
                MODE_PUSH:
                begin
                    if (full)
                        st = ST_DROPPED;
                    else
                    begin
                        wr_en      = 1'b1;
                        wp_next    = (wp_reg == LAST_ADDR) ? '0 : wp_reg + PW'(1);
                        st         = ST_STORED;
                        fill_after = fill + PW'(1);
                    end
                end
                MODE_PULL:
                begin
                    started_now  = started_reg || (fill_ext >= CW'(thr_reg));
                    started_next = started_now;
                    if (!started_now)
                        st = ST_PREBUF;
                    else
                    begin
                        // silence decision is taken once, at the frame start
                        silent_now  = (pos_reg == '0) ? (fill_ext < CW'(flen)) : silent_reg;
                        silent_next = silent_now;
                        if (silent_now)
                            st = ST_SILENCE;
                        else
                        begin
                            rd_en      = 1'b1;
                            rp_next    = (rp_reg == LAST_ADDR) ? '0 : rp_reg + PW'(1);
                            st         = ST_RING;
                            fill_after = fill - PW'(1);
                        end
                        last     = ((FLEN_W'(pos_reg) + FLEN_W'(1)) >= flen);
                        pos_next = last ? '0 : pos_reg + POS_W'(1);
                    end
                end
                default:
                begin
                    started_next = 1'b0;
                    pos_next     = '0;
                    silent_next  = 1'b0;
                    st           = ST_CLIENT;
                end
            endcase
        end
    end

    // push and pull are separate words, so a read never meets a write in one cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= item.sample_in;
        if (rd_en)
            rdata_reg <= mem[rp_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            started_reg   <= 1'b0;
            pos_reg       <= '0;
            silent_reg    <= 1'b0;
            thr_reg       <= THR_RESET;
            flen_reg      <= FLEN_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            started_reg <= started_next;
            pos_reg     <= pos_next;
            silent_reg  <= silent_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PREBUF: thr_reg  <= cfg_data[THR_W-1:0];
                    CFG_FRAME:  flen_reg <= cfg_data[FLEN_W-1:0];
                endcase
            end
            if (item_ready)
                s1_valid_reg <= item_valid;
            if (s1_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= st;
            s1_last_reg   <= last;
            s1_fill_reg   <= FILL_W'(CW'(fill_after));
            s1_ring_reg   <= rd_en;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_reg.status     <= s1_status_reg;
            out_reg.sample_out <= s1_ring_reg ? $signed(rdata_reg) : '0;
            out_reg.frame_last <= s1_last_reg;
            out_reg.fill_level <= s1_fill_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`include "audio_jitter_buffer_top_assert.svh"

    `AJB_ASSERT_IMP(a_ptr_range, clk, rst_n, 1'b1, (wp_reg <= LAST_ADDR) && (rp_reg <= LAST_ADDR))
    `AJB_ASSERT_NEXT(a_rdata_hold, clk, rst_n, s1_valid_reg && s1_ring_reg && !s1_adv, $stable(rdata_reg))
    `AJB_ASSERT_IMP(a_no_pop_empty, clk, rst_n, rd_en, fill != '0)
    `AJB_ASSERT_IMP(a_stall_full, clk, rst_n, item_ready && !s1_adv, !s1_valid_reg)

endmodule
